// ----- hw/rtl/box_average_downscale_4x4_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 4x4 box downscaler
// Implication and next-cycle implication checks; empty without assertions.
// ----------------------------------------------------------------------------
`ifndef BOX_AVERAGE_DOWNSCALE_4X4_UNIT_DEFINES_SVH
`define BOX_AVERAGE_DOWNSCALE_4X4_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BAD4_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BAD4_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BAD4_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BAD4_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/bad4_pkg.sv -----
// ----------------------------------------------------------------------------
// bad4_pkg
// Shared types and constants of the 4x4 box downscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bad4_pkg;

	localparam int unsigned MAX_WIDTH = 1024;
	localparam int unsigned GROUPS_MAX = MAX_WIDTH / 4;
	localparam int unsigned SLOT_W = $clog2(GROUPS_MAX);
	localparam int unsigned BANDS_MAX = 256;

	localparam int unsigned SUM_W = 12;
	localparam int unsigned QUAD_W = 10;
	localparam int unsigned ADDR_W = 20;
	localparam int unsigned PADDR_W = 4;

	localparam logic [1:0] REG_REGION_WIDTH = 2'd0;
	localparam logic [1:0] REG_REGION_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEST_STRIDE = 2'd2;

	localparam logic [10:0] RESET_REGION_WIDTH = 11'd640;
	localparam logic [10:0] RESET_REGION_HEIGHT = 11'd480;
	localparam logic [12:0] RESET_DEST_STRIDE = 13'd160;

	localparam logic [1:0] ROW_FIRST = 2'd0;
	localparam logic [1:0] ROW_LAST = 2'd3;

	localparam int unsigned FIFO_DEPTH = 3;
	localparam int unsigned FIFO_PTR_W = 2;
	localparam int unsigned FIFO_CNT_W = 2;

	typedef struct packed {
		logic [7:0]        average;
		logic [ADDR_W-1:0] dest_address;
		logic              frame_last;
	} result_t;

	typedef struct packed {
		logic                  push;
		logic                  pop;
	} fifo_ctrl_t;

endpackage

// ----- hw/rtl/bad4_in_if.sv -----
// ----------------------------------------------------------------------------
// bad4_in_if
// Pixel channel: four adjacent 8-bit pixels per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bad4_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pix_a;
	logic [7:0] pix_b;
	logic [7:0] pix_c;
	logic [7:0] pix_d;

	modport source (output valid, output pix_a, output pix_b, output pix_c, output pix_d,
		input ready);
	modport sink (input valid, input pix_a, input pix_b, input pix_c, input pix_d,
		output ready);
endinterface

// ----- hw/rtl/bad4_out_if.sv -----
// ----------------------------------------------------------------------------
// bad4_out_if
// Result channel: one averaged block and its destination address per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bad4_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  average;
	logic [19:0] dest_address;
	logic        frame_last;

	modport source (output valid, output average, output dest_address, output frame_last,
		input ready);
	modport sink (input valid, input average, input dest_address, input frame_last,
		output ready);
endinterface

// ----- hw/rtl/box_average_downscale_4x4_unit.sv -----
// ----------------------------------------------------------------------------
// box_average_downscale_4x4_unit
// 4x4 box-filter downscaler with a 256-entry partial-sum line store.
// ----------------------------------------------------------------------------
// Takes one transfer of four pixels per cycle, sustained, whatever the output
// side does while the three-entry result queue has room. A block's result goes
// via the stage-1 registers into that queue. The line store is one
// 256 x 12 synchronous memory with one read and one write per cycle; a
// last-write register forwards a sum to a following item of the same column
// group, so back-to-back transfers never wait on the memory. No clearing pass.
`timescale 1ns / 1ps
`include "box_average_downscale_4x4_unit_defines.svh"

module box_average_downscale_4x4_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	bad4_in_if.sink                           pix_in,
	bad4_out_if.source                        blk_out,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bad4_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int unsigned SW = bad4_pkg::SLOT_W;
	localparam int unsigned AW = bad4_pkg::ADDR_W;

	// configuration
	logic [10:0] region_width_q;
	logic [10:0] region_height_q;
	logic [12:0] dest_stride_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_width_q <= bad4_pkg::RESET_REGION_WIDTH;
			region_height_q <= bad4_pkg::RESET_REGION_HEIGHT;
			dest_stride_q <= bad4_pkg::RESET_DEST_STRIDE;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				bad4_pkg::REG_REGION_WIDTH:  region_width_q <= pwdata[10:0];
				bad4_pkg::REG_REGION_HEIGHT: region_height_q <= pwdata[10:0];
				bad4_pkg::REG_DEST_STRIDE:   dest_stride_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			bad4_pkg::REG_REGION_WIDTH:  prdata = {21'd0, region_width_q};
			bad4_pkg::REG_REGION_HEIGHT: prdata = {21'd0, region_height_q};
			bad4_pkg::REG_DEST_STRIDE:   prdata = {19'd0, dest_stride_q};
			default:                     prdata = '0;
		endcase
	end

	// group and band limits, 1..256
	logic [8:0] groups;
	logic [8:0] bands;

	always_comb begin
		groups = region_width_q[10:2];
		if (groups == 9'd0) begin
			groups = 9'd1;
		end else if (groups > 9'(bad4_pkg::GROUPS_MAX)) begin
			groups = 9'(bad4_pkg::GROUPS_MAX);
		end
		bands = region_height_q[10:2];
		if (bands == 9'd0) begin
			bands = 9'd1;
		end else if (bands > 9'(bad4_pkg::BANDS_MAX)) begin
			bands = 9'(bad4_pkg::BANDS_MAX);
		end
	end

	// position counters
	logic [SW-1:0] column_group_q;
	logic [1:0]    row_in_band_q;
	logic [7:0]    band_row_q;
	logic [AW-1:0] band_base_q;
	logic          last_group;
	logic          last_band;
	logic          acc;

	assign last_group = ({1'b0, column_group_q} + 9'd1) >= groups;
	assign last_band = ({1'b0, band_row_q} + 9'd1) >= bands;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_group_q <= '0;
			row_in_band_q <= bad4_pkg::ROW_FIRST;
			band_row_q <= '0;
			band_base_q <= '0;
		end else if (acc) begin
			if (last_group) begin
				column_group_q <= '0;
				if (row_in_band_q == bad4_pkg::ROW_LAST) begin
					row_in_band_q <= bad4_pkg::ROW_FIRST;
					if (last_band) begin
						band_row_q <= '0;
						band_base_q <= '0;
					end else begin
						band_row_q <= band_row_q + 8'd1;
						band_base_q <= band_base_q + AW'(dest_stride_q);
					end
				end else begin
					row_in_band_q <= row_in_band_q + 2'd1;
				end
			end else begin
				column_group_q <= column_group_q + 1'b1;
			end
		end
	end

	// stage 1: line-store read data arrives, sum is written back or emitted
	logic                        valid_s1;
	logic [SW-1:0]               slot_s1;
	logic [1:0]                  row_s1;
	logic [bad4_pkg::QUAD_W-1:0] quad_s1;
	logic [AW-1:0]               addr_s1;
	logic                        last_s1;
	logic [bad4_pkg::SUM_W-1:0]  rdata_s1;
	logic [bad4_pkg::QUAD_W-1:0] quad;
	logic                        emit_s1;

	assign quad = bad4_pkg::QUAD_W'(pix_in.pix_a) + bad4_pkg::QUAD_W'(pix_in.pix_b)
		+ bad4_pkg::QUAD_W'(pix_in.pix_c) + bad4_pkg::QUAD_W'(pix_in.pix_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			slot_s1 <= column_group_q;
			row_s1 <= row_in_band_q;
			quad_s1 <= quad;
			addr_s1 <= band_base_q + AW'(column_group_q);
			last_s1 <= last_group && last_band;
		end
	end

	// line store and last-write forward register
	logic [bad4_pkg::SUM_W-1:0] band_sums [bad4_pkg::GROUPS_MAX];
	logic                       mem_we;
	logic [bad4_pkg::SUM_W-1:0] operand;
	logic [bad4_pkg::SUM_W:0]   total;
	logic                       fwd_valid_q;
	logic [SW-1:0]              fwd_addr_q;
	logic [bad4_pkg::SUM_W-1:0] fwd_data_q;

	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1 <= band_sums[column_group_q];
		end
		if (mem_we) begin
			band_sums[slot_s1] <= total[bad4_pkg::SUM_W-1:0];
		end
	end

	always_comb begin
		if (row_s1 == bad4_pkg::ROW_FIRST) begin
			operand = '0;
		end else if (fwd_valid_q && (fwd_addr_q == slot_s1)) begin
			operand = fwd_data_q;
		end else begin
			operand = rdata_s1;
		end
	end

	assign total = {1'b0, operand} + (bad4_pkg::SUM_W + 1)'(quad_s1);
	assign emit_s1 = valid_s1 && (row_s1 == bad4_pkg::ROW_LAST);
	assign mem_we = valid_s1 && (row_s1 != bad4_pkg::ROW_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (mem_we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fwd_addr_q <= slot_s1;
			fwd_data_q <= total[bad4_pkg::SUM_W-1:0];
		end
	end

	// result queue
	bad4_pkg::fifo_ctrl_t            fifo_ctrl;
	bad4_pkg::result_t               fifo_wr;
	bad4_pkg::result_t               fifo_rd;
	logic                            fifo_ne;
	logic [bad4_pkg::FIFO_CNT_W-1:0] fifo_count;
	logic [bad4_pkg::FIFO_CNT_W:0]   committed;

	assign fifo_wr.average = total[11:4];
	assign fifo_wr.dest_address = addr_s1;
	assign fifo_wr.frame_last = last_s1;
	assign fifo_ctrl.push = emit_s1;
	assign fifo_ctrl.pop = blk_out.valid && blk_out.ready;

	bad4_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (fifo_ctrl),
		.wr_data   (fifo_wr),
		.rd_data   (fifo_rd),
		.not_empty (fifo_ne),
		.count     (fifo_count)
	);

	assign committed = {1'b0, fifo_count} + {{bad4_pkg::FIFO_CNT_W{1'b0}}, emit_s1};
	assign pix_in.ready = committed < (bad4_pkg::FIFO_CNT_W + 1)'(bad4_pkg::FIFO_DEPTH);
	assign acc = pix_in.valid && pix_in.ready;

	assign blk_out.valid = fifo_ne;
	assign blk_out.average = fifo_rd.average;
	assign blk_out.dest_address = fifo_rd.dest_address;
	assign blk_out.frame_last = fifo_rd.frame_last;

	`BAD4_ASSERT_NXT(a_emit_follows, clk, arst_n,
		acc && (row_in_band_q == bad4_pkg::ROW_LAST), emit_s1)
	`BAD4_ASSERT_NXT(a_group_wraps, clk, arst_n, acc && last_group, column_group_q == '0)
	`BAD4_ASSERT_NXT(a_fwd_tracks, clk, arst_n, mem_we,
		fwd_valid_q && (fwd_addr_q == $past(slot_s1)))

endmodule

// ----- hw/rtl/bad4_out_fifo.sv -----
// ----------------------------------------------------------------------------
// bad4_out_fifo
// Three-entry result queue between the line-store stage and the output port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_average_downscale_4x4_unit_defines.svh"

module bad4_out_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bad4_pkg::fifo_ctrl_t             ctrl,
	input  bad4_pkg::result_t                wr_data,
	output bad4_pkg::result_t                rd_data,
	output logic                             not_empty,
	output logic [bad4_pkg::FIFO_CNT_W-1:0]  count
);

	bad4_pkg::result_t mem_q [bad4_pkg::FIFO_DEPTH];
	logic [bad4_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [bad4_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [bad4_pkg::FIFO_CNT_W-1:0] count_q;

	localparam logic [bad4_pkg::FIFO_PTR_W-1:0] PTR_LAST =
		bad4_pkg::FIFO_PTR_W'(bad4_pkg::FIFO_DEPTH - 1);
	localparam logic [bad4_pkg::FIFO_CNT_W-1:0] CNT_FULL =
		bad4_pkg::FIFO_CNT_W'(bad4_pkg::FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (ctrl.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (ctrl.pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (ctrl.push && !ctrl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (!ctrl.push && ctrl.pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count = count_q;

	`BAD4_ASSERT_IMP(a_no_overflow, clk, arst_n, ctrl.push, count_q != CNT_FULL)
	`BAD4_ASSERT_IMP(a_no_underflow, clk, arst_n, ctrl.pop, count_q != '0)
	`BAD4_ASSERT_NXT(a_push_grows, clk, arst_n, ctrl.push && !ctrl.pop,
		count_q == $past(count_q) + 1'b1)

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 4x4 box downscaler. Pixel words are streamed
// under several region settings and flow-control patterns; every block result
// is compared with an in-bench model of the line store and counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class block_mean_tracker;
	logic [10:0] region_width;
	logic [10:0] region_height;
	logic [12:0] dest_stride;
	logic [11:0] partial_sums [bad4_pkg::GROUPS_MAX];
	logic [7:0]  column_group;
	logic [1:0]  row_in_band;
	logic [7:0]  band_row;
	logic [19:0] band_base;
	bad4_pkg::result_t pending_blocks [$];
	int unsigned mismatches;

	function new();
		region_width = bad4_pkg::RESET_REGION_WIDTH;
		region_height = bad4_pkg::RESET_REGION_HEIGHT;
		dest_stride = bad4_pkg::RESET_DEST_STRIDE;
		foreach (partial_sums[i])
			partial_sums[i] = '0;
		column_group = '0;
		row_in_band = bad4_pkg::ROW_FIRST;
		band_row = '0;
		band_base = '0;
		mismatches = 0;
	endfunction

	function int unsigned group_limit(logic [10:0] width);
		int unsigned g;
		g = 32'(width >> 2);
		if (g == 0)
			g = 1;
		if (g > bad4_pkg::GROUPS_MAX)
			g = bad4_pkg::GROUPS_MAX;
		return g;
	endfunction

	function int unsigned band_limit(logic [10:0] height);
		int unsigned b;
		b = 32'(height >> 2);
		if (b == 0)
			b = 1;
		if (b > bad4_pkg::BANDS_MAX)
			b = bad4_pkg::BANDS_MAX;
		return b;
	endfunction

	function void write_register(logic [1:0] index, logic [31:0] value);
		case (index)
			bad4_pkg::REG_REGION_WIDTH: region_width = value[10:0];
			bad4_pkg::REG_REGION_HEIGHT: region_height = value[10:0];
			bad4_pkg::REG_DEST_STRIDE: dest_stride = value[12:0];
			default: ;
		endcase
	endfunction

	function void take_pixels(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
		int unsigned groups;
		int unsigned bands;
		int unsigned quad;
		int unsigned total;
		bit last_group;
		bit last_band;
		bad4_pkg::result_t blk;
		groups = group_limit(region_width);
		bands = band_limit(region_height);
		quad = 32'(a) + 32'(b) + 32'(c) + 32'(d);
		last_group = (32'(column_group) + 1) >= groups;
		last_band = (32'(band_row) + 1) >= bands;

		if (row_in_band == bad4_pkg::ROW_FIRST) begin
			partial_sums[column_group] = quad[11:0];
		end else if (row_in_band != bad4_pkg::ROW_LAST) begin
			partial_sums[column_group] = partial_sums[column_group] + quad[11:0];
		end else begin
			total = 32'(partial_sums[column_group]) + quad;
			blk.average = total[11:4];
			blk.dest_address = band_base + 20'(column_group);
			blk.frame_last = last_group && last_band;
			pending_blocks.push_back(blk);
		end

		if (last_group) begin
			column_group = '0;
			if (row_in_band == bad4_pkg::ROW_LAST) begin
				row_in_band = bad4_pkg::ROW_FIRST;
				if (last_band) begin
					band_row = '0;
					band_base = '0;
				end else begin
					band_row = band_row + 8'd1;
					band_base = band_base + 20'(dest_stride);
				end
			end else begin
				row_in_band = row_in_band + 2'd1;
			end
		end else begin
			column_group = column_group + 8'd1;
		end
	endfunction

	task report_mismatch(string msg);
		if (mismatches < 40)
			$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task check_block(bad4_pkg::result_t got);
		bad4_pkg::result_t want;
		if (pending_blocks.size() == 0) begin
			report_mismatch($sformatf("unexpected block avg %0d addr 0x%05h last %0b",
				got.average, got.dest_address, got.frame_last));
			return;
		end
		want = pending_blocks.pop_front();
		if (got.average !== want.average)
			report_mismatch($sformatf("average %0d, want %0d", got.average, want.average));
		if (got.dest_address !== want.dest_address)
			report_mismatch($sformatf("dest_address 0x%05h, want 0x%05h",
				got.dest_address, want.dest_address));
		if (got.frame_last !== want.frame_last)
			report_mismatch($sformatf("frame_last %0b, want %0b",
				got.frame_last, want.frame_last));
	endtask

	task drop_missing();
		report_mismatch($sformatf("%0d expected blocks never arrived", pending_blocks.size()));
		pending_blocks.delete();
	endtask
endclass

module tb_top;

	typedef enum {IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH} idle_mode_t;

	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_LIMIT = 20000;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [bad4_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;

	int unsigned src_idle_pct = 0;
	int unsigned snk_stall_pct = 0;
	int unsigned hold_cycles = 0;
	idle_mode_t  deep_modes [4] = '{IDLE_NONE, IDLE_SOURCE, IDLE_SINK, IDLE_BOTH};
	block_mean_tracker tracker;

	bad4_in_if  pix_if();
	bad4_out_if blk_if();

	box_average_downscale_4x4_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_if),
		.blk_out (blk_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// result side: check each transfer, then pick the next ready
	initial begin
		bad4_pkg::result_t got;
		blk_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (blk_if.valid && blk_if.ready) begin
				got.average = blk_if.average;
				got.dest_address = blk_if.dest_address;
				got.frame_last = blk_if.frame_last;
				tracker.check_block(got);
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				blk_if.ready <= 1'b0;
			end else begin
				blk_if.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	function automatic logic [7:0] some_pixel();
		if ($urandom_range(9) == 0)
			return $urandom_range(1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(255));
	endfunction

	function automatic void set_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin src_idle_pct = 0; snk_stall_pct = 0; end
			IDLE_SOURCE: begin src_idle_pct = 87; snk_stall_pct = 0; end
			IDLE_SINK: begin src_idle_pct = 0; snk_stall_pct = 87; end
			default: begin src_idle_pct = 13; snk_stall_pct = 13; end
		endcase
	endfunction

	task automatic apb_write(logic [1:0] index, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracker.write_register(index, value);
	endtask

	task automatic send_item(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pix_a <= a;
		pix_if.pix_b <= b;
		pix_if.pix_c <= c;
		pix_if.pix_d <= d;
		do @(posedge clk); while (!pix_if.ready);
		tracker.take_pixels(a, b, c, d);
	endtask

	task automatic run_items(int unsigned count);
		repeat (count)
			send_item(some_pixel(), some_pixel(), some_pixel(), some_pixel());
	endtask

	task automatic wait_drained();
		int unsigned waited;
		waited = 0;
		pix_if.valid <= 1'b0;
		while (tracker.pending_blocks.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (tracker.pending_blocks.size() != 0)
			tracker.drop_missing();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [10:0] width, logic [10:0] height, logic [12:0] stride);
		// widen only on a band's first row, so no store entry is read before written
		if (tracker.group_limit(width) > tracker.group_limit(tracker.region_width))
			while (tracker.row_in_band != bad4_pkg::ROW_FIRST)
				run_items(1);
		wait_drained();
		apb_write(bad4_pkg::REG_REGION_WIDTH, 32'(width));
		apb_write(bad4_pkg::REG_REGION_HEIGHT, 32'(height));
		apb_write(bad4_pkg::REG_DEST_STRIDE, 32'(stride));
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pix_if.valid = 1'b0;
		pix_if.pix_a = '0;
		pix_if.pix_b = '0;
		pix_if.pix_c = '0;
		pix_if.pix_d = '0;
		set_idle(IDLE_NONE);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-scale and zero blocks, one group, height below one band
		configure(11'd6, 11'd2, 13'd1);
		repeat (4) send_item(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		repeat (4) send_item(8'h00, 8'h00, 8'h00, 8'h00);

		// oversized width, zero height; then shrink with the column past the limit
		configure(11'd2047, 11'd0, 13'd4096);
		run_items(5);
		configure(11'd10, 11'd13, 13'd8191);
		run_items(7);

		configure(11'd16, 11'd16, 13'd5);
		set_idle(IDLE_NONE);
		run_items(64);

		set_idle(IDLE_SOURCE);
		configure(11'd8, 11'd12, 13'd3);
		run_items(24);

		set_idle(IDLE_SINK);
		configure(11'd1024, 11'd1024, 13'd4096);
		run_items(12);
		configure(11'd12, 11'd4, 13'd0);
		run_items(24);

		// one group, large pitch: band base wraps past 2^20; output held off first
		set_idle(IDLE_NONE);
		configure(11'd0, 11'd2047, 13'd8191);
		hold_cycles = 200;
		foreach (deep_modes[i]) begin
			set_idle(deep_modes[i]);
			run_items(130);
		end

		// band row well past the new band count
		set_idle(IDLE_BOTH);
		configure(11'd3, 11'd8, 13'd2);
		run_items(24);

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bad4_pkg.sv
hw/rtl/bad4_in_if.sv
hw/rtl/bad4_out_if.sv
hw/rtl/bad4_out_fifo.sv
hw/rtl/box_average_downscale_4x4_unit.sv
dv/tb_top.sv
